// ===== src/ols_pkg.sv =====
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and constants of the ordered list store: sizes, request kinds,
// status codes, entry layout and memory port control.
// ----------------------------------------------------------------------------
package ols_pkg;

  // list size and entry widths
  localparam int DEPTH        = 32;
  localparam int KEY_BITS     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // item field widths
  localparam int KIND_W    = 3;
  localparam int POS_W     = 5;
  localparam int IN_KEY_W  = 64;
  localparam int IN_PAY_W  = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 6;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // entry memory port control
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_ctl_t;

endpackage

// ===== src/ols_entry_mem.sv =====
// ----------------------------------------------------------------------------
// ols_entry_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ols_entry_mem (
  input  logic              clk,
  input  ols_pkg::mem_ctl_t ctl,
  input  ols_pkg::entry_t   wr_entry,
  output ols_pkg::entry_t   rd_entry_r
);
  import ols_pkg::*;

  entry_t mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wr_entry;
    end
    rd_entry_r <= mem[ctl.raddr];
  end

endmodule

// ===== src/ordered_list_store_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Ordered list of key/payload entries with clear, insert, delete, read,
// update and find, walked one entry per cycle through one read and one write port.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    in_kind in_append in_position in_key    start high, busy low
//           in_payload
//  result   out_status out_found_position           out_valid, one cycle,
//           out_read_key out_read_payload           no back pressure
//           out_entry_count
//
//  clear, append, update, delete of the last entry, unused kinds and every
//  refused request answer in the cycle after acceptance and leave busy low.
//  insert before position n walks count-n entries, delete at n walks
//  count-n-1, find walks up to count and read walks a single entry.
//  busy drops in the result cycle, so the next item can follow at once.
//  rst_n empties the list; entries need no clearing.
//  results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module ordered_list_store_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ols_pkg::KIND_W-1:0]       in_kind,
  input  logic                             in_append,
  input  logic [ols_pkg::POS_W-1:0]        in_position,
  input  logic [ols_pkg::IN_KEY_W-1:0]     in_key,
  input  logic [ols_pkg::IN_PAY_W-1:0]     in_payload,
  output logic                             out_valid,
  output logic [ols_pkg::STATUS_W-1:0]     out_status,
  output logic [ols_pkg::POS_W-1:0]        out_found_position,
  output logic [ols_pkg::IN_KEY_W-1:0]     out_read_key,
  output logic [ols_pkg::IN_PAY_W-1:0]     out_read_payload,
  output logic [ols_pkg::OUT_CNT_W-1:0]    out_entry_count
);
  import ols_pkg::*;

  // sequencer and request registers
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  entry_t              entry_r, entry_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   last_r, last_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                issue_r, issue_nxt;

  // result registers
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [POS_W-1:0]      out_fpos_r, out_fpos_nxt;
  logic [IN_KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [IN_PAY_W-1:0]   out_pay_r, out_pay_nxt;
  logic [OUT_CNT_W-1:0]  out_count_r, out_count_nxt;

  // memory interface and walk control
  mem_ctl_t            mem_ctl;
  entry_t              mem_wdata;
  entry_t              rd_entry_r;
  logic                walk_go;
  logic                walk_end;
  logic [CNT_W-1:0]    pos_ext;
  logic                key_hit;

  ols_entry_mem u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .wr_entry   (mem_wdata),
    .rd_entry_r (rd_entry_r)
  );

  assign pos_ext = CNT_W'(in_position);
  assign key_hit = (rd_entry_r.key == entry_r.key);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && walk_go) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request decode, walk stepping and result forming
  always_comb begin
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    entry_nxt      = entry_r;
    ptr_nxt        = ptr_r;
    last_nxt       = last_r;
    left_nxt       = left_r;
    issue_nxt      = issue_r;
    mem_ctl        = '0;
    mem_wdata      = entry_r;
    walk_go        = 1'b0;
    walk_end       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_fpos_nxt   = '0;
    out_key_nxt    = '0;
    out_pay_nxt    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt      = in_kind;
          pos_nxt       = ADDR_W'(in_position);
          entry_nxt     = '{key: in_key[KEY_BITS-1:0], payload: in_payload[PAYLOAD_BITS-1:0]};
          issue_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          case (in_kind)
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else if (in_append) begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = count_r[ADDR_W-1:0];
                mem_wdata     = entry_nxt;
                count_nxt     = count_r + 1'b1;
              end else if (pos_ext >= count_r) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                // shift entries pos..count-1 up, last one first
                out_valid_nxt = 1'b0;
                walk_go       = 1'b1;
                ptr_nxt       = ADDR_W'(count_r - 1'b1);
                left_nxt      = count_r - pos_ext;
              end
            end
            KIND_DELETE, KIND_READ, KIND_UPDATE: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else if (pos_ext >= count_r) begin
                out_status_nxt = STAT_BADPOS;
              end else if (in_kind == KIND_UPDATE) begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = ADDR_W'(in_position);
                mem_wdata     = entry_nxt;
              end else if (in_kind == KIND_READ) begin
                out_valid_nxt = 1'b0;
                walk_go       = 1'b1;
                ptr_nxt       = ADDR_W'(in_position);
                left_nxt      = CNT_W'(1);
              end else if (pos_ext == count_r - 1'b1) begin
                // last entry: nothing to move
                count_nxt = count_r - 1'b1;
              end else begin
                // shift entries pos+1..count-1 down
                out_valid_nxt = 1'b0;
                walk_go       = 1'b1;
                ptr_nxt       = ADDR_W'(in_position) + 1'b1;
                left_nxt      = count_r - 1'b1 - pos_ext;
              end
            end
            KIND_FIND: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                walk_go       = 1'b1;
                ptr_nxt       = '0;
                left_nxt      = count_r;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        mem_ctl.raddr = ptr_r;

        // issue the next read
        if (left_r != '0) begin
          issue_nxt = 1'b1;
          last_nxt  = ptr_r;
          left_nxt  = left_r - 1'b1;
          ptr_nxt   = (kind_r == KIND_INSERT) ? ptr_r - 1'b1 : ptr_r + 1'b1;
        end else begin
          issue_nxt = 1'b0;
        end

        // consume the entry read last cycle
        if (issue_r) begin
          case (kind_r)
            KIND_INSERT: begin
              mem_ctl.we    = 1'b1;
              mem_ctl.waddr = last_r + 1'b1;
              mem_wdata     = rd_entry_r;
            end
            KIND_DELETE: begin
              mem_ctl.we    = 1'b1;
              mem_ctl.waddr = last_r - 1'b1;
              mem_wdata     = rd_entry_r;
            end
            KIND_READ: begin
              walk_end      = 1'b1;
              out_valid_nxt = 1'b1;
              out_key_nxt   = IN_KEY_W'(rd_entry_r.key);
              out_pay_nxt   = IN_PAY_W'(rd_entry_r.payload);
            end
            KIND_FIND: begin
              if (key_hit) begin
                walk_end      = 1'b1;
                out_valid_nxt = 1'b1;
                out_fpos_nxt  = POS_W'(last_r);
                out_key_nxt   = IN_KEY_W'(rd_entry_r.key);
                out_pay_nxt   = IN_PAY_W'(rd_entry_r.payload);
              end
            end
            default: ;
          endcase
        end

        // walk drained: finish the request
        if (left_r == '0 && !issue_r) begin
          walk_end      = 1'b1;
          out_valid_nxt = 1'b1;
          case (kind_r)
            KIND_INSERT: begin
              mem_ctl.we    = 1'b1;
              mem_ctl.waddr = pos_r;
              mem_wdata     = entry_r;
              count_nxt     = count_r + 1'b1;
            end
            KIND_DELETE: begin
              count_nxt = count_r - 1'b1;
            end
            KIND_FIND: begin
              out_status_nxt = STAT_NOTFOUND;
            end
            default: ;
          endcase
        end
      end

      default: ;
    endcase

    out_count_nxt = OUT_CNT_W'(count_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    entry_r      <= entry_nxt;
    ptr_r        <= ptr_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
  end

  // ports
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_read_key       = out_key_r;
  assign out_read_payload   = out_pay_r;
  assign out_entry_count    = out_count_r;

endmodule
